// ----- src/krt_pkg.sv -----
// Shared types and constants for the keyed record table.
// Operation and status codes, entry layout, result bundle.
// No dependencies.
package krt_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = KEY_W + DATA_W;
    localparam int SLOT_W     = 6;
    localparam int CNT_OUT_W  = 7;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;
    localparam int M_PAD_W    = M_TDATA_W - (SLOT_W + DATA_W + 2 * CNT_OUT_W);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [DATA_W-1:0]      out_data;
        logic [CNT_OUT_W-1:0]   removed;
        logic [CNT_OUT_W-1:0]   fill_count;
    } res_t;

endpackage

// ----- src/keyed_record_table_core.sv -----
// Insert writes the next free slot with no scan; lookup/update scan the filled slots
// up to the first match; delete scans them all, moving the last entry into each removed
// slot. One request in flight; the next is taken once the sequencer is idle, even while
// the output register still holds a result. One RAM read port sets the one-slot-per-cycle
// scan, paused while a delete moves an entry. Reset clears the fill count and the control
// state only; the entry RAM is not cleared and needs no clearing pass.
module keyed_record_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [krt_pkg::S_TDATA_W-1:0]     s_tdata,   // key[31:0], in_data[63:32]
    input  logic [1:0]                        s_tuser,   // kind[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [krt_pkg::M_TDATA_W-1:0]     m_tdata,   // slot[5:0], out_data[37:6],
                                                         // removed[44:38], fill_count[51:45]
    output logic [1:0]                        m_tuser    // status[1:0]
);
    import krt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 res_valid;
    logic                 res_ready;
    res_t                 res;

    // output register, decouples result delivery from the sequencer
    logic                 m_valid_reg, m_valid_next;
    res_t                 m_res_reg,   m_res_next;

    krt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    krt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (op_t'(s_tuser)),
        .req_key   (s_tdata[KEY_W-1:0]),
        .req_data  (s_tdata[KEY_W +: DATA_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // result register may load when empty or draining this cycle
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.fill_count, m_res_reg.removed,
                       m_res_reg.out_data, m_res_reg.slot};

endmodule

// ----- src/krt_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module krt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/krt_ctrl.sv -----
// Operation sequencer for the keyed record table: fill count, slot scan,
// read-modify-write of the entry RAM. Depends on krt_pkg.
module krt_ctrl #(
    parameter int TABLE_DEPTH = 64,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request side
    input  logic                          req_valid,
    output logic                          req_ready,
    input  krt_pkg::op_t                  req_op,
    input  logic [krt_pkg::KEY_W-1:0]     req_key,
    input  logic [krt_pkg::DATA_W-1:0]    req_data,
    // result side
    output logic                          res_valid,
    input  logic                          res_ready,
    output krt_pkg::res_t                 res,
    // entry RAM
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [krt_pkg::ENTRY_W-1:0]   ram_wdata,
    output logic [IDX_W-1:0]              ram_raddr,
    input  logic [krt_pkg::ENTRY_W-1:0]   ram_rdata
);
    import krt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_FETCH  = 5'b00100,
        S_MOVE   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t              state_reg,    state_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    op_t                 op_reg,       op_next;
    logic [KEY_W-1:0]    key_reg,      key_next;
    logic [DATA_W-1:0]   data_reg,     data_next;
    logic [CNT_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]    chk_idx_reg,  chk_idx_next;
    logic                pend_reg,     pend_next;
    logic [CNT_W-1:0]    removed_reg,  removed_next;
    logic [IDX_W-1:0]    first_reg,    first_next;
    res_t                res_reg,      res_next;

    logic [KEY_W-1:0]    rd_key;
    logic [DATA_W-1:0]   rd_data;
    logic                hit;
    logic [IDX_W-1:0]    last_idx;

    assign rd_key   = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_data  = ram_rdata[DATA_W-1:0];
    assign hit      = pend_reg && (rd_key == key_reg);
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res       = res_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        data_next     = data_reg;
        scan_idx_next = scan_idx_reg;
        chk_idx_next  = chk_idx_reg;
        pend_next     = pend_reg;
        removed_next  = removed_reg;
        first_next    = first_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = chk_idx_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = scan_idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next       = req_op;
                    key_next      = req_key;
                    data_next     = req_data;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    removed_next  = '0;
                    first_next    = '0;
                    res_next      = '0;
                    if (req_op == OP_INSERT) begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            res_next.status     = ST_FULL;
                            res_next.fill_count = CNT_OUT_W'(count_reg);
                        end else begin
                            ram_we              = 1'b1;
                            ram_waddr           = count_reg[IDX_W-1:0];
                            ram_wdata           = {req_key, req_data};
                            count_next          = count_reg + CNT_W'(1);
                            res_next.status     = ST_OK;
                            res_next.slot       = SLOT_W'(count_reg);
                            res_next.fill_count = CNT_OUT_W'(count_reg + CNT_W'(1));
                        end
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (hit) begin
                    pend_next = 1'b0;
                    res_next  = '0;
                    res_next.fill_count = CNT_OUT_W'(count_reg);
                    case (op_reg)
                        OP_LOOKUP: begin
                            res_next.status   = ST_OK;
                            res_next.slot     = SLOT_W'(chk_idx_reg);
                            res_next.out_data = rd_data;
                            state_next        = S_FINISH;
                        end
                        OP_UPDATE: begin
                            ram_we            = 1'b1;
                            ram_waddr         = chk_idx_reg;
                            ram_wdata         = {key_reg, data_reg};
                            res_next.status   = ST_OK;
                            res_next.slot     = SLOT_W'(chk_idx_reg);
                            res_next.out_data = rd_data;
                            state_next        = S_FINISH;
                        end
                        OP_DELETE: begin
                            if (removed_reg == '0) begin
                                first_next = chk_idx_reg;
                            end
                            state_next = S_FETCH;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end else if (scan_idx_reg < count_reg) begin
                    // issue next read; the compare of the previous one runs alongside
                    pend_next     = 1'b1;
                    chk_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    res_next  = '0;
                    res_next.fill_count = CNT_OUT_W'(count_reg);
                    if (removed_reg != '0) begin
                        res_next.status  = ST_OK;
                        res_next.slot    = SLOT_W'(first_reg);
                        res_next.removed = CNT_OUT_W'(removed_reg);
                    end else begin
                        res_next.status  = ST_MISSING;
                    end
                    state_next = S_FINISH;
                end
            end

            S_FETCH: begin
                ram_raddr  = last_idx;
                state_next = S_MOVE;
            end

            S_MOVE: begin
                // last entry lands on the matched slot; resume past it
                ram_we        = 1'b1;
                ram_waddr     = chk_idx_reg;
                ram_wdata     = ram_rdata;
                count_next    = count_reg - CNT_W'(1);
                removed_next  = removed_reg + CNT_W'(1);
                scan_idx_next = CNT_W'(chk_idx_reg) + CNT_W'(1);
                state_next    = S_SCAN;
            end

            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        data_reg     <= data_next;
        scan_idx_reg <= scan_idx_next;
        chk_idx_reg  <= chk_idx_next;
        removed_reg  <= removed_next;
        first_reg    <= first_next;
        res_reg      <= res_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    a_move_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE) |-> (count_reg != '0))
        else $error("entry move with empty table");

    a_pend_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && pend_reg) |-> (CNT_W'(chk_idx_reg) < count_reg))
        else $error("compare on slot beyond fill count");

    a_no_write_idle_ram: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != S_FETCH && state_reg != S_FINISH))
        else $error("RAM write outside a write state");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && !res_ready) |=>
            (state_reg == S_FINISH && $stable(res_reg) && $stable(count_reg)))
        else $error("pending result changed");
`endif

endmodule
